// ===== rtl/kes_pkg.sv =====
// kes_pkg: shared types, constants and helper functions for the kepler solver
// used by kes_ctrl, kes_dp and kepler_equation_solver; no dependencies
package kes_pkg;

    localparam int MAX_ITERATIONS = 16;
    localparam int STEPS_W        = 7;
    localparam int CORDIC_STAGES  = 28;
    localparam int DIV_STEPS      = 32;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ECC_CUTOFF = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_LIMIT = 8'd1;

    localparam logic [15:0] ECC_CUTOFF_RST = 16'd3277;
    localparam logic [19:0] CONV_LIMIT_RST = 20'd4685;

    localparam logic signed [35:0] Q28_PI        = 36'sd843314857;
    localparam logic signed [35:0] Q28_TWO_PI    = 36'sd1686629713;
    localparam logic signed [35:0] Q28_HALF_PI   = 36'sd421657428;
    localparam logic signed [35:0] Q28_ANGLE_SAT = 36'sd1610612736;
    localparam logic signed [35:0] Q30_ONE       = 36'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
    localparam logic [31:0]        QUOT_SAT      = 32'h8000_0000;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_CINIT, OP_CSTEP, OP_CFIN,
        OP_MUL_EC, OP_U, OP_MUL_SU, OP_P, OP_MUL_EP, OP_Q, OP_EST,
        OP_MUL_ES, OP_F, OP_FP, OP_DINIT, OP_DSTEP, OP_NEXT, OP_UPD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_last;
        logic div_last;
        logic refine;
        logic hit;
    } t_dp_stat;

    // arctangent of 2^-i in q28, rounded
    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd210828714;
            5'd1: v = 32'sd124459457;
            5'd2: v = 32'sd65760959;
            5'd3: v = 32'sd33381290;
            5'd4: v = 32'sd16755422;
            5'd5: v = 32'sd8385879;
            5'd6: v = 32'sd4193963;
            5'd7: v = 32'sd2097109;
            5'd8: v = 32'sd1048571;
            5'd9: v = 32'sd524287;
            default: v = 32'sd1 <<< (5'd28 - i);
        endcase
        return v;
    endfunction

    // round v / 2^s to nearest, ties away from zero
    function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                       input int unsigned s);
        logic [65:0] mag;
        logic [65:0] r;
        mag = v[65] ? 66'(-v) : 66'(v);
        r   = (mag + (66'd1 << (s - 1))) >> s;
        return v[65] ? -$signed(r) : $signed(r);
    endfunction

    // v / 2^i truncated toward zero
    function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                  input logic [4:0] i);
        logic [33:0] mag;
        mag = v[33] ? 34'(-v) : 34'(v);
        mag = mag >> i;
        return v[33] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [35:0] clamp_angle(input logic signed [35:0] v);
        if (v > Q28_ANGLE_SAT) return Q28_ANGLE_SAT;
        if (v < -Q28_ANGLE_SAT) return -Q28_ANGLE_SAT;
        return v;
    endfunction

endpackage

// ===== rtl/kepler_equation_solver.sv =====
// kepler_equation_solver: one result per item, from the series estimate alone
// when there is no refinement; each newton step adds a pass of the
// 28-stage cordic and the 32-step divider, up to MAX_ITERATIONS steps.
// one item at a time, busy high until done; the next item can be taken at the
// edge that ends the one-cycle result strobe, which cannot be stalled.
// synchronous active-low reset: idle, control and configuration registers back to defaults.
// holds the configuration registers; depends on kes_pkg, kes_ctrl, kes_dp
module kepler_equation_solver
    import kes_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic signed [30:0]     i_mean_anomaly,
    input  logic [15:0]            i_eccentricity,
    output logic                   o_valid,
    output logic signed [31:0]     o_ecc_anomaly,
    output logic [STEPS_W-1:0]     o_steps_taken,
    output logic                   o_converged,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [15:0] r_ecc_cutoff;
    logic [19:0] r_conv_limit;
    t_dp_cmd     cmd;
    t_dp_stat    stat;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecc_cutoff <= ECC_CUTOFF_RST;
            r_conv_limit <= CONV_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ECC_CUTOFF: r_ecc_cutoff <= i_cfg_data[15:0];
                CFG_CONV_LIMIT: r_conv_limit <= i_cfg_data[19:0];
                default:        r_ecc_cutoff <= r_ecc_cutoff;
            endcase
        end
    end

    kes_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_steps_taken (o_steps_taken),
        .o_converged   (o_converged)
    );

    kes_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_mean_anomaly (i_mean_anomaly),
        .i_eccentricity (i_eccentricity),
        .i_ecc_cutoff   (r_ecc_cutoff),
        .i_conv_limit   (r_conv_limit),
        .o_stat         (stat),
        .o_ecc_anomaly  (o_ecc_anomaly)
    );

endmodule

// ===== rtl/kes_dp.sv =====
// kes_dp: solver datapath with iterative cordic, one shared multiplier,
// and a radix-2 restoring divider; depends on kes_pkg
module kes_dp
    import kes_pkg::*;
(
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [30:0]        i_mean_anomaly,
    input  logic [15:0]               i_eccentricity,
    input  logic [15:0]               i_ecc_cutoff,
    input  logic [19:0]               i_conv_limit,
    output t_dp_stat                  o_stat,
    output logic signed [31:0]        o_ecc_anomaly
);

    logic signed [30:0] r_m;
    logic [15:0]        r_e;
    logic signed [31:0] r_ang, r_ea, r_next;
    logic signed [33:0] r_x, r_y, r_z, r_s, r_c, r_u, r_p, r_q;
    logic               r_flip;
    logic [4:0]         r_ci;
    logic signed [65:0] r_prod;
    logic signed [35:0] r_f;
    logic signed [33:0] r_fp;
    logic               r_fneg, r_qsat;
    logic [32:0]        r_rem;
    logic [31:0]        r_dlo, r_quo;
    logic [4:0]         r_di;
    logic               r_refine;

    logic signed [35:0] z0;
    logic               flip0;
    logic signed [33:0] dx, dy;
    logic signed [31:0] at;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [35:0] fabs_s;
    logic [35:0]        fabs;
    logic [33:0]        rem2;
    logic [32:0]        dmag;
    logic signed [35:0] dsig, nxt, est, fpt;
    logic signed [35:0] diff;
    logic [35:0]        dabs;

    // range wrap and quadrant fold for the cordic argument
    always_comb begin
        z0    = 36'(r_ang);
        flip0 = 1'b0;
        if (z0 > Q28_PI) z0 = z0 - Q28_TWO_PI;
        if (z0 < -Q28_PI) z0 = z0 + Q28_TWO_PI;
        if (z0 > Q28_HALF_PI) begin
            z0    = Q28_PI - z0;
            flip0 = 1'b1;
        end else if (z0 < -Q28_HALF_PI) begin
            z0    = -Q28_PI - z0;
            flip0 = 1'b1;
        end
    end

    // one rotation per cycle
    assign dx = shr_tz(r_y, r_ci);
    assign dy = shr_tz(r_x, r_ci);
    assign at = atan_entry(r_ci);

    // shared multiplier operand select
    always_comb begin
        mul_a = 34'($signed({1'b0, r_e}));
        mul_b = r_c;
        case (i_cmd.op)
            OP_MUL_SU: begin
                mul_a = r_s;
                mul_b = r_u;
            end
            OP_MUL_EP: mul_b = r_p;
            OP_MUL_ES: mul_b = r_s;
            default:   mul_b = r_c;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider and step update
    assign fabs_s = r_f[35] ? -r_f : r_f;
    assign fabs   = 36'(fabs_s);
    assign rem2   = {r_rem, r_dlo[31]};
    assign dmag   = r_qsat ? 33'(QUOT_SAT)
                  : ((r_quo > QUOT_SAT) ? 33'(QUOT_SAT) : {1'b0, r_quo});
    assign dsig   = r_fneg ? -36'($signed({1'b0, dmag})) : 36'($signed({1'b0, dmag}));
    assign nxt    = clamp_angle(36'(r_ea) - dsig);
    assign est    = clamp_angle(36'(r_m) + 36'(round_shift(66'(r_q), 2)));
    assign fpt    = Q30_ONE - 36'(round_shift(r_prod, 16));
    assign diff   = 36'(r_ea) - 36'(r_next);
    assign dabs   = diff[35] ? 36'(-diff) : 36'(diff);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_m      <= i_mean_anomaly;
                r_e      <= i_eccentricity;
                r_ang    <= 32'(i_mean_anomaly);
                r_refine <= (i_eccentricity > i_ecc_cutoff);
            end
            OP_CINIT: begin
                r_z    <= 34'(z0);
                r_flip <= flip0;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_ci   <= '0;
            end
            OP_CSTEP: begin
                if (!r_z[33]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - 34'(at);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + 34'(at);
                end
                r_ci <= r_ci + 5'd1;
            end
            OP_CFIN: begin
                r_s <= r_y;
                r_c <= r_flip ? -r_x : r_x;
            end
            OP_MUL_EC, OP_MUL_SU, OP_MUL_EP, OP_MUL_ES: r_prod <= 66'(mul_p);
            OP_U: r_u <= 34'(Q30_ONE + 36'(round_shift(r_prod, 16)));
            OP_P: r_p <= 34'(round_shift(r_prod, 30));
            OP_Q: r_q <= 34'(round_shift(r_prod, 16));
            OP_EST: begin
                r_ea  <= 32'(est);
                r_ang <= 32'(est);
            end
            OP_F: r_f <= 36'(r_ea) - 36'(round_shift(r_prod, 18)) - 36'(r_m);
            OP_FP: r_fp <= (fpt < 36'sd1) ? 34'sd1 : 34'(fpt);
            OP_DINIT: begin
                r_fneg <= r_f[35];
                r_qsat <= (fabs >= {r_fp[33:0], 2'b00});
                r_rem  <= 33'(fabs >> 2);
                r_dlo  <= {fabs[1:0], 30'd0};
                r_quo  <= '0;
                r_di   <= '0;
            end
            OP_DSTEP: begin
                if (rem2 >= 34'(r_fp)) begin
                    r_rem <= 33'(rem2 - 34'(r_fp));
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem2[32:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_dlo <= {r_dlo[30:0], 1'b0};
                r_di  <= r_di + 5'd1;
            end
            OP_NEXT: r_next <= 32'(nxt);
            OP_UPD: begin
                r_ea  <= r_next;
                r_ang <= r_next;
            end
            default: r_ci <= r_ci;
        endcase
    end

    assign o_stat.cordic_last = (r_ci == 5'(CORDIC_STAGES - 1));
    assign o_stat.div_last    = (r_di == 5'(DIV_STEPS - 1));
    assign o_stat.refine      = r_refine;
    assign o_stat.hit         = (dabs <= 36'(i_conv_limit));
    assign o_ecc_anomaly      = r_ea;

endmodule

// ===== rtl/kes_ctrl.sv =====
// kes_ctrl: sequencer for the series estimate and newton refinement
// drives kes_dp by operation codes; depends on kes_pkg
module kes_ctrl
    import kes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_dp_stat             i_stat,
    output t_dp_cmd              o_cmd,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [STEPS_W-1:0]   o_steps_taken,
    output logic                 o_converged
);

    typedef enum logic [4:0] {
        S_IDLE, S_CINIT, S_CSTEP, S_CFIN,
        S_M1, S_U, S_M2, S_P, S_M3, S_Q, S_EST,
        S_NM1, S_NF, S_NM2, S_NFP, S_DINIT, S_DSTEP, S_NEXT, S_UPD
    } t_state;

    t_state               r_state;
    logic                 r_newton, r_valid, r_conv;
    logic [STEPS_W-1:0]   r_steps;

    // operation decode from state
    always_comb begin
        case (r_state)
            S_IDLE:  o_cmd.op = i_start ? OP_LOAD : OP_NOP;
            S_CINIT: o_cmd.op = OP_CINIT;
            S_CSTEP: o_cmd.op = OP_CSTEP;
            S_CFIN:  o_cmd.op = OP_CFIN;
            S_M1:    o_cmd.op = OP_MUL_EC;
            S_U:     o_cmd.op = OP_U;
            S_M2:    o_cmd.op = OP_MUL_SU;
            S_P:     o_cmd.op = OP_P;
            S_M3:    o_cmd.op = OP_MUL_EP;
            S_Q:     o_cmd.op = OP_Q;
            S_EST:   o_cmd.op = OP_EST;
            S_NM1:   o_cmd.op = OP_MUL_ES;
            S_NF:    o_cmd.op = OP_F;
            S_NM2:   o_cmd.op = OP_MUL_EC;
            S_NFP:   o_cmd.op = OP_FP;
            S_DINIT: o_cmd.op = OP_DINIT;
            S_DSTEP: o_cmd.op = OP_DSTEP;
            S_NEXT:  o_cmd.op = OP_NEXT;
            S_UPD:   o_cmd.op = OP_UPD;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newton <= 1'b0;
            r_valid  <= 1'b0;
            r_conv   <= 1'b0;
            r_steps  <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_newton <= 1'b0;
                    r_steps  <= '0;
                    r_state  <= S_CINIT;
                end
                S_CINIT: r_state <= S_CSTEP;
                S_CSTEP: if (i_stat.cordic_last) r_state <= S_CFIN;
                S_CFIN:  r_state <= r_newton ? S_NM1 : S_M1;
                S_M1:    r_state <= S_U;
                S_U:     r_state <= S_M2;
                S_M2:    r_state <= S_P;
                S_P:     r_state <= S_M3;
                S_M3:    r_state <= S_Q;
                S_Q:     r_state <= S_EST;
                S_EST: begin
                    if (i_stat.refine) begin
                        r_newton <= 1'b1;
                        r_state  <= S_CINIT;
                    end else begin
                        r_conv  <= 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_NM1:   r_state <= S_NF;
                S_NF:    r_state <= S_NM2;
                S_NM2:   r_state <= S_NFP;
                S_NFP:   r_state <= S_DINIT;
                S_DINIT: r_state <= S_DSTEP;
                S_DSTEP: if (i_stat.div_last) r_state <= S_NEXT;
                S_NEXT:  r_state <= S_UPD;
                S_UPD: begin
                    r_steps <= r_steps + STEPS_W'(1);
                    if (i_stat.hit) begin
                        r_conv  <= 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_steps == STEPS_W'(MAX_ITERATIONS - 1)) begin
                        r_conv  <= 1'b0;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CINIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_steps_taken = r_steps;
    assign o_converged   = r_conv;

endmodule

// ===== sim/testbench.sv =====
// testbench for kepler_equation_solver: directed and random anomalies checked
// against a built-in fixed-point newton solver; depends on kes_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import kes_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'hA5;
    localparam longint ANOMALY_PI = 64'sd843314857;
    localparam int     ITEM_TOTAL = 950;

    typedef struct {
        logic signed [31:0] anomaly;
        logic [STEPS_W-1:0] steps;
        logic               conv;
    } t_anomaly;

    // scoreboard: fixed-point kepler solver and queue of pending anomalies
    class t_anomaly_board;
        t_anomaly pending_q[$];
        longint   cutoff = 3277;
        longint   limit  = 4685;
        int       errors, results, capped, refined;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ECC_CUTOFF) cutoff = data[15:0];
            else if (idx == CFG_CONV_LIMIT) limit = data[19:0];
        endfunction

        function longint round_q(longint v, int s);
            longint half;
            half = 64'sd1 <<< (s - 1);
            if (v >= 0) return (v + half) >>> s;
            return -((-v + half) >>> s);
        endfunction

        function longint sat(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function longint arctan_q28(int i);
            case (i)
                0: return 210828714;
                1: return 124459457;
                2: return 65760959;
                3: return 33381290;
                4: return 16755422;
                5: return 8385879;
                6: return 4193963;
                7: return 2097109;
                8: return 1048571;
                9: return 524287;
                default: return 64'sd1 <<< (28 - i);
            endcase
        endfunction

        // rotation cordic, q28 angle in, q30 sine/cosine out
        function void sine_cosine(longint ang, output longint s, output longint c);
            longint z, x, y, dx, dy;
            bit flip;
            z = ang; x = 652032874; y = 0; flip = 0;
            if (z > ANOMALY_PI) z -= 64'sd1686629713;
            if (z < -ANOMALY_PI) z += 64'sd1686629713;
            if (z > 64'sd421657428) begin
                z = ANOMALY_PI - z; flip = 1;
            end else if (z < -64'sd421657428) begin
                z = -ANOMALY_PI - z; flip = 1;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                dx = y / (64'sd1 <<< i);
                dy = x / (64'sd1 <<< i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= arctan_q28(i);
                end else begin
                    x += dx; y -= dy; z += arctan_q28(i);
                end
            end
            s = y;
            c = flip ? -x : x;
        endfunction

        function void note_item(logic signed [30:0] mean, logic [15:0] ecc);
            longint m, e, sv, cv, u, p, q, ea, f, fp, d, nxt, diff;
            t_anomaly r;
            m = mean; e = ecc;
            r.steps = 0; r.conv = 1;
            // series estimate
            sine_cosine(m, sv, cv);
            u  = 64'sd1073741824 + round_q(e * cv, 16);
            p  = round_q(sv * u, 30);
            q  = round_q(e * p, 16);
            ea = sat(m + round_q(q, 2), 64'sd1610612736);
            // newton refinement
            if (e > cutoff) begin
                refined++;
                r.conv = 0;
                while (r.steps < MAX_ITERATIONS) begin
                    sine_cosine(ea, sv, cv);
                    f  = ea - round_q(e * sv, 18) - m;
                    fp = 64'sd1073741824 - round_q(e * cv, 16);
                    if (fp < 1) fp = 1;
                    d    = sat((f * 64'sd1073741824) / fp, 64'sd2147483648);
                    nxt  = sat(ea - d, 64'sd1610612736);
                    diff = ea - nxt;
                    if (diff < 0) diff = -diff;
                    ea = nxt;
                    r.steps++;
                    if (diff <= limit) begin
                        r.conv = 1;
                        break;
                    end
                end
                if (!r.conv) capped++;
            end
            r.anomaly = ea[31:0];
            pending_q.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check(logic signed [31:0] anomaly, logic [STEPS_W-1:0] steps, logic conv);
            t_anomaly x;
            results++;
            if (pending_q.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            x = pending_q.pop_front();
            if (anomaly !== x.anomaly)
                report($sformatf("ecc_anomaly %0d, want %0d", anomaly, x.anomaly));
            if (steps !== x.steps)
                report($sformatf("steps_taken %0d, want %0d", steps, x.steps));
            if (conv !== x.conv)
                report($sformatf("converged %0b, want %0b", conv, x.conv));
        endtask
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_start = 0;
    logic signed [30:0]    i_mean_anomaly = '0;
    logic [15:0]           i_eccentricity = '0;
    logic                  i_cfg_valid = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_busy, o_valid, o_converged, o_cfg_ready;
    logic signed [31:0]    o_ecc_anomaly;
    logic [STEPS_W-1:0]    o_steps_taken;

    t_anomaly_board board = new();
    int  sent = 0;
    bit  calm = 0;

    kepler_equation_solver dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // result monitor
    always @(posedge i_clk)
        if (i_rst_n && o_valid) board.check(o_ecc_anomaly, o_steps_taken, o_converged);

    // send one item, then maybe a gap
    task send_item(longint mean, longint ecc);
        i_start        <= 1;
        i_mean_anomaly <= mean[30:0];
        i_eccentricity <= ecc[15:0];
        do @(posedge i_clk); while (o_busy);
        board.note_item(mean[30:0], ecc[15:0]);
        sent++;
        if (!calm && $urandom_range(0, 2) == 0) begin
            i_start <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task wait_drained();
        i_start <= 0;
        @(posedge i_clk);
        while (board.pending_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // random anomaly: mostly reduced, sometimes anything in 31 bits
    function longint rand_mean();
        case ($urandom_range(0, 9))
            0: return longint'($signed(31'($urandom())));
            1: return $urandom_range(0, 1) ? ANOMALY_PI : -ANOMALY_PI;
            default: return longint'($urandom_range(0, 1686629714)) - ANOMALY_PI;
        endcase
    endfunction

    function longint rand_ecc();
        case ($urandom_range(0, 5))
            0: return $urandom_range(60000, 65535);
            1: return $urandom_range(0, 4000);
            2: return longint'(board.cutoff) + $urandom_range(0, 2) - 1 & 16'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin
        #60_000_000;
        $display("timeout at %0t", $time);
        $display("simulation failed");
        $finish;
    end

    initial begin
        longint edge_m[6];
        int     quota;
        edge_m = '{0, ANOMALY_PI, -ANOMALY_PI, 64'sd1073741823, -64'sd1073741824, 1};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, field extremes, cutoff boundary
        foreach (edge_m[k]) begin
            send_item(edge_m[k], 0);
            send_item(edge_m[k], 65535);
        end
        send_item(300000000, 3277);
        send_item(300000000, 3278);
        send_item(-500000000, 40000);
        wait_drained();

        // limit zero: step cap almost always reached
        write_reg(CFG_ECC_CUTOFF, 0);
        write_reg(CFG_CONV_LIMIT, 0);
        send_item(0, 1);
        send_item(ANOMALY_PI, 65535);
        send_item(-700000000, 50000);
        send_item(1073741823, 65535);
        wait_drained();

        // refinement off, oversized data and an unused index
        write_reg(CFG_ECC_CUTOFF, 32'hFFFF_FFFF);
        write_reg(CFG_CONV_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_IDX, 32'h0000_0001);
        send_item(-1073741824, 65535);
        send_item(500000000, 65535);
        wait_drained();
        write_reg(CFG_ECC_CUTOFF, 0);
        send_item(500000000, 65535);
        send_item(-200000000, 1);
        wait_drained();

        // random phases with random register settings
        while (sent < ITEM_TOTAL) begin
            case ($urandom_range(0, 4))
                0: write_reg(CFG_ECC_CUTOFF, $urandom_range(0, 65535));
                1: write_reg(CFG_ECC_CUTOFF, $urandom_range(0, 1) ? 0 : 65535);
                default: write_reg(CFG_ECC_CUTOFF, $urandom_range(0, 8000));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_CONV_LIMIT, $urandom_range(1, 1048575));
                1: write_reg(CFG_CONV_LIMIT, $urandom_range(0, 1) ? 1 : 1048575);
                2: write_reg(CFG_CONV_LIMIT, 0);
                default: write_reg(CFG_CONV_LIMIT, $urandom_range(1, 6000));
            endcase
            calm = (sent > ITEM_TOTAL - 100);
            quota = (board.limit == 0) ? 15 : $urandom_range(40, 120);
            for (int n = 0; n < quota; n++) begin
                send_item(rand_mean(), rand_ecc());
                if (n == quota / 2 && $urandom_range(0, 3) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (board.pending_q.size() != 0)
            board.report($sformatf("%0d results never arrived", board.pending_q.size()));
        $display("%0d items sent, %0d results checked, %0d mismatches",
                 sent, board.results, board.errors);
        $display("%0d items refined by newton steps, %0d stopped at the step cap",
                 board.refined, board.capped);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== kepler_equation_solver.f =====
rtl/kes_pkg.sv
rtl/kes_dp.sv
rtl/kes_ctrl.sv
rtl/kepler_equation_solver.sv
sim/testbench.sv
